FILE: sv/btmx_pkg.sv
// ----------------------------------------------------------------------------
// btmx_pkg
// Shared types and constants for the binary trie maximum XOR unit.
// ----------------------------------------------------------------------------
`default_nettype none

package btmx_pkg;

  // Fixed widths of the beat fields.
  localparam int FIELD_W = 32;

  // Defaults for the top-level parameters.
  localparam int KEY_WIDTH_DEF  = 32;
  localparam int NODE_COUNT_DEF = 32768;

  // Node numbering: node 0 means "no child", node 1 is the root.
  localparam int ROOT_NODE  = 1;
  localparam int FIRST_FREE = 2;

  // Input beat.
  typedef struct packed {
    logic [FIELD_W-1:0] key;
    logic               start_set;
  } item_t;

  // Result beat.
  typedef struct packed {
    logic [FIELD_W-1:0] best_xor;
    logic [FIELD_W-1:0] running_max;
    logic               table_full;
  } result_t;

endpackage

`default_nettype wire

FILE: sv/binary_trie_max_xor_unit.sv
// ----------------------------------------------------------------------------
// binary_trie_max_xor_unit
// Inserts keys into a binary trie and reports the largest XOR with any
// earlier key of the current set, together with the running maximum.
// ----------------------------------------------------------------------------
// Each accepted key goes through these steps in order: accept, one trie
// level per cycle, close the new leaf, post the result. The walk down the
// trie runs through a single node memory whose two read ports serve the
// lookup walk and the insert walk side by side. A rejected key skips the
// walk and the leaf step and goes straight to posting its result beat.
// The result sits in an output register, so a new key is taken as soon as
// the previous one has finished, even if its result beat has not yet been
// collected; a key that finishes while an earlier beat is still uncollected
// waits until that beat is taken. A key is rejected with table_full set
// when fewer than KEY_WIDTH free nodes remain; start_set on a beat empties
// the trie and clears the maximum before that key is handled. The node
// memory needs no clearing pass: the root lives in registers and every
// other node is written before its contents are used.
`default_nettype none

module binary_trie_max_xor_unit
  import btmx_pkg::*;
#(
  parameter int KEY_WIDTH  = KEY_WIDTH_DEF,
  parameter int NODE_COUNT = NODE_COUNT_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    item_valid,
  output logic         item_ready,
  input  wire item_t   item,
  output logic         result_valid,
  input  wire logic    result_ready,
  output result_t      result
);

  localparam int IDX_W   = $clog2(NODE_COUNT);
  localparam int CNT_W   = $clog2(NODE_COUNT + 1);
  localparam int LVL_W   = (KEY_WIDTH > 1) ? $clog2(KEY_WIDTH) : 1;
  localparam int TOP_LVL = KEY_WIDTH - 1;

  typedef struct packed {
    logic [IDX_W-1:0] one;
    logic [IDX_W-1:0] zero;
  } node_t;

  typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_LEAF, ST_DONE} state_t;

  // Node memory: both child pointers of a node in one word.
  node_t mem [NODE_COUNT];

  state_t             state;
  logic [LVL_W-1:0]   lvl;
  logic [KEY_WIDTH-1:0] key_reg;
  logic [KEY_WIDTH-1:0] best_reg;
  node_t              root;
  logic [CNT_W-1:0]   next_free;
  logic [FIELD_W-1:0] best_so_far;
  logic               set_has_keys;
  logic               lk_stop;
  logic               fresh;
  logic               full;
  logic [IDX_W-1:0]   in_node;
  node_t              lk_rdata;
  node_t              in_rdata;

  // Key taken to KEY_WIDTH bits.
  logic [63:0]          key_wide;
  logic [KEY_WIDTH-1:0] key_in;

  assign key_wide = 64'(item.key);
  assign key_in   = key_wide[KEY_WIDTH-1:0];

  // Capacity check against the node count that holds after a possible new set.
  logic [CNT_W-1:0] nf_eff;
  logic [CNT_W-1:0] free_cnt;
  logic             is_full;
  logic             has_eff;

  assign nf_eff   = item.start_set ? CNT_W'(FIRST_FREE) : next_free;
  assign free_cnt = CNT_W'(NODE_COUNT) - nf_eff;
  assign is_full  = free_cnt < CNT_W'(KEY_WIDTH);
  assign has_eff  = item.start_set ? 1'b0 : set_has_keys;

  assign item_ready = (state == ST_IDLE);

  // One trie level: lookup step and insert step on the current entries.
  logic             is_top;
  logic             bit_k;
  node_t            lk_ent;
  node_t            in_ent;
  logic [IDX_W-1:0] lk_alt;
  logic [IDX_W-1:0] lk_same;
  logic [IDX_W-1:0] lk_addr;
  logic             lk_bit;
  logic             lk_stop_next;
  logic [IDX_W-1:0] in_child;
  logic [IDX_W-1:0] alloc;
  node_t            upd;
  node_t            fresh_ent;
  logic [IDX_W-1:0] in_addr;
  logic             do_alloc;
  logic             root_wr;
  logic             mem_we;
  logic [IDX_W-1:0] wr_addr;
  node_t            wr_data;

  always_comb begin
    is_top  = (lvl == LVL_W'(TOP_LVL));
    bit_k   = key_reg[lvl];
    lk_ent  = is_top ? root : lk_rdata;
    in_ent  = is_top ? root : in_rdata;

    // Lookup: prefer the child with the opposite bit.
    lk_alt       = bit_k ? lk_ent.zero : lk_ent.one;
    lk_same      = bit_k ? lk_ent.one : lk_ent.zero;
    lk_addr      = lk_same;
    lk_bit       = 1'b0;
    lk_stop_next = lk_stop;
    if (lk_stop) begin
      lk_bit = bit_k;
    end else if (lk_alt != '0) begin
      lk_bit  = 1'b1;
      lk_addr = lk_alt;
    end else if (lk_same != '0) begin
      lk_bit  = 1'b0;
      lk_addr = lk_same;
    end else begin
      lk_bit       = bit_k;
      lk_stop_next = 1'b1;
    end

    // Insert: follow the existing path, then hang a chain of new nodes.
    in_child  = bit_k ? in_ent.one : in_ent.zero;
    alloc     = next_free[IDX_W-1:0];
    upd       = in_ent;
    fresh_ent = '0;
    if (bit_k) begin
      upd.one       = alloc;
      fresh_ent.one = alloc;
    end else begin
      upd.zero       = alloc;
      fresh_ent.zero = alloc;
    end
    in_addr  = in_child;
    do_alloc = 1'b0;
    root_wr  = 1'b0;
    mem_we   = 1'b0;
    wr_addr  = in_node;
    wr_data  = upd;
    if (state == ST_WALK) begin
      if (fresh) begin
        in_addr  = alloc;
        do_alloc = 1'b1;
        mem_we   = 1'b1;
        wr_data  = fresh_ent;
      end else if (in_child == '0) begin
        in_addr  = alloc;
        do_alloc = 1'b1;
        if (is_top) begin
          root_wr = 1'b1;
        end else begin
          mem_we = 1'b1;
        end
      end
    end else if (state == ST_LEAF) begin
      // The last new node is a leaf with no children.
      mem_we  = fresh;
      wr_data = '0;
    end
  end

  // Node memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    lk_rdata <= mem[lk_addr];
    in_rdata <= mem[in_addr];
  end

  // Result of the finished key.
  logic [63:0]        best_wide;
  logic [FIELD_W-1:0] best_val;
  logic [FIELD_W-1:0] max_val;

  assign best_wide = 64'(best_reg);
  assign best_val  = (full || !set_has_keys) ? '0 : best_wide[FIELD_W-1:0];
  assign max_val   = (best_val > best_so_far) ? best_val : best_so_far;

  // Sequencer and trie bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      root         <= '0;
      next_free    <= CNT_W'(FIRST_FREE);
      best_so_far  <= '0;
      set_has_keys <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // A collected beat empties the output register unless a new one replaces it.
      if (result_valid && result_ready && state != ST_DONE) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            key_reg <= key_in;
            if (item.start_set) begin
              root         <= '0;
              next_free    <= CNT_W'(FIRST_FREE);
              best_so_far  <= '0;
              set_has_keys <= 1'b0;
            end
            full    <= is_full;
            lk_stop <= ~has_eff;
            fresh   <= 1'b0;
            in_node <= IDX_W'(ROOT_NODE);
            lvl     <= LVL_W'(TOP_LVL);
            state   <= is_full ? ST_DONE : ST_WALK;
          end
        end
        ST_WALK: begin
          best_reg[lvl] <= lk_bit;
          lk_stop       <= lk_stop_next;
          if (root_wr) begin
            root <= wr_data;
          end
          if (do_alloc) begin
            next_free <= next_free + CNT_W'(1);
            fresh     <= 1'b1;
          end
          in_node <= in_addr;
          if (lvl == '0) begin
            state <= ST_LEAF;
          end else begin
            lvl <= lvl - LVL_W'(1);
          end
        end
        ST_LEAF: begin
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid       <= 1'b1;
            result.best_xor    <= best_val;
            result.running_max <= max_val;
            result.table_full  <= full;
            if (!full) begin
              best_so_far  <= max_val;
              set_has_keys <= 1'b1;
            end
            state <= ST_IDLE;
          end else begin
            result_valid <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
